FILE: design/assert_macros.svh
// Assertion helpers for the figure table block.
// Both macros reduce to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion, disabled while reset is asserted
`define PIF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define PIF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PIF_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIF_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

FILE: design/pif_pkg.sv
package pif_pkg;

  // Fixed field widths
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 2;
  localparam int PNUM_W     = 16;
  localparam int FNUM_W     = 5;
  localparam int NUM_COORDS = 6;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Figure kinds
  localparam logic [KIND_W-1:0] KIND_RECT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CIRC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRI  = 2'd2;

  // Point counter saturation value
  localparam logic [PNUM_W-1:0] PNUM_MAX = '1;

  // Accumulator operations of the shared multiply unit
  typedef enum logic [1:0] {
    MAC_LOAD,   // acc = prod
    MAC_ADD,    // acc = acc + prod
    MAC_SUB,    // acc = acc - prod
    MAC_RSUB    // acc = prod - acc
  } mac_op_e;

  typedef struct packed {
    logic    mul_en;
    logic    acc_en;
    mac_op_e op;
  } mac_ctrl_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } mac_sign_t;

endpackage

FILE: design/pif_in_if.sv
interface pif_in_if #(
  parameter int COORD_BITS = 24
);
  import pif_pkg::*;

  logic                         valid;
  logic                         ready;
  logic        [CMD_W-1:0]      cmd;
  logic        [KIND_W-1:0]     kind;
  logic signed [COORD_BITS-1:0] coord_a;
  logic signed [COORD_BITS-1:0] coord_b;
  logic signed [COORD_BITS-1:0] coord_c;
  logic signed [COORD_BITS-1:0] coord_d;
  logic signed [COORD_BITS-1:0] coord_e;
  logic signed [COORD_BITS-1:0] coord_f;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (
    output valid, cmd, kind, coord_a, coord_b, coord_c, coord_d, coord_e, coord_f,
           point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, cmd, kind, coord_a, coord_b, coord_c, coord_d, coord_e, coord_f,
           point_x, point_y,
    output ready
  );

endinterface

FILE: design/pif_out_if.sv
interface pif_out_if;
  import pif_pkg::*;

  logic              valid;
  logic              ready;
  logic [PNUM_W-1:0] point_number;
  logic [FNUM_W-1:0] figure_number;
  logic              contained;
  logic              last;

  modport source (
    output valid, point_number, figure_number, contained, last,
    input  ready
  );

  modport sink (
    input  valid, point_number, figure_number, contained, last,
    output ready
  );

endinterface

FILE: design/pif_store.sv
module pif_store #(
  parameter  int DEPTH  = 16,
  parameter  int WIDTH  = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  // One row per figure
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/pif_mac.sv
module pif_mac #(
  parameter int OP_W = 25
) (
  input  logic                   clk_i,
  input  pif_pkg::mac_ctrl_t     ctrl_i,
  input  logic signed [OP_W-1:0] op_a_i,
  input  logic signed [OP_W-1:0] op_b_i,
  output pif_pkg::mac_sign_t     sign_o
);
  import pif_pkg::*;

  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = ACC_W'(prod_q);

  // Accumulator update
  always_comb begin
    case (ctrl_i.op)
      MAC_LOAD: acc_d = prod_ext;
      MAC_ADD:  acc_d = acc_q + prod_ext;
      MAC_SUB:  acc_d = acc_q - prod_ext;
      MAC_RSUB: acc_d = prod_ext - acc_q;
      default:  acc_d = prod_ext;
    endcase
  end

  // Product register, then accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign sign_o.neg = acc_q[ACC_W-1];
  assign sign_o.pos = !acc_q[ACC_W-1] && (acc_q != '0);

endmodule

FILE: design/point_in_figure_table_test.sv
// Figure table point test. Add words store a rectangle, circle or triangle in the next
// table slot (adds past MAX_FIGURES are dropped); a clear word empties the table and
// zeroes the point counter; a query word tests the point strictly against every stored
// figure in order and returns one word per containing figure, or one not-contained word,
// with last set on the final word. A query's duration per stored figure is set by the
// single shared multiplier and accumulator, which registers each product before it is
// accumulated (three products for a circle, six for a triangle), and by the registered
// read of the figure memory.
// The input is not ready while a query is in progress; a result word waiting in the
// output register stalls the scan only when a further word is ready to be sent.
`include "assert_macros.svh"

module point_in_figure_table_test #(
  parameter int MAX_FIGURES = 16,
  parameter int COORD_BITS  = 24
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  pif_in_if.sink  in_i,
  pif_out_if.source out_o
);
  import pif_pkg::*;

  localparam int CNT_W  = $clog2(MAX_FIGURES + 1);
  localparam int ADDR_W = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
  localparam int ROW_W  = NUM_COORDS * COORD_BITS + KIND_W;
  localparam int OP_W   = COORD_BITS + 1;

  localparam logic [CNT_W-1:0] FIG_MAX        = CNT_W'(MAX_FIGURES);
  localparam logic [2:0]       STEP_CIRC_LAST = 3'd2;
  localparam logic [2:0]       STEP_TRI_LAST  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_MUL,
    ST_ACC,
    ST_SIGN,
    ST_RESULT,
    ST_FINISH
  } state_e;

  state_e                       state_q, state_d;
  logic        [CNT_W-1:0]      fig_count_q, fig_count_d;
  logic        [PNUM_W-1:0]     pnt_cnt_q, pnt_cnt_d;
  logic        [CNT_W-1:0]      idx_q, idx_d;
  logic        [2:0]            step_q, step_d;
  logic                         hit_q, hit_d;
  logic        [1:0]            tri_pos_q, tri_pos_d;
  logic        [1:0]            tri_neg_q, tri_neg_d;
  logic signed [COORD_BITS-1:0] px_q, px_d;
  logic signed [COORD_BITS-1:0] py_q, py_d;
  logic                         pend_v_q, pend_v_d;
  logic        [FNUM_W-1:0]     pend_fig_q, pend_fig_d;
  logic                         out_valid_q, out_valid_d;
  logic        [PNUM_W-1:0]     out_pnum_q, out_pnum_d;
  logic        [FNUM_W-1:0]     out_fig_q, out_fig_d;
  logic                         out_cont_q, out_cont_d;
  logic                         out_last_q, out_last_d;

  logic                         in_ready;
  logic                         in_fire;
  logic                         out_free;
  logic                         wr_en;
  logic                         rd_en;
  logic        [ROW_W-1:0]      row_data;
  logic        [KIND_W-1:0]     row_kind;
  logic signed [COORD_BITS-1:0] coord [NUM_COORDS];
  logic signed [OP_W-1:0]       vx [3];
  logic signed [OP_W-1:0]       vy [3];
  logic signed [OP_W-1:0]       pxe, pye;
  logic signed [OP_W-1:0]       ax, ay, bx, by;
  logic signed [OP_W-1:0]       op_a, op_b;
  mac_op_e                      sel_op;
  mac_ctrl_t                    mac_ctrl;
  mac_sign_t                    mac_sign;
  logic                         rect_hit;
  logic                         last_step;
  logic                         scan_done;
  logic        [FNUM_W-1:0]     cur_fig;

  // Figure memory
  assign wr_en = in_fire && (in_i.cmd == CMD_ADD) && (fig_count_q < FIG_MAX);

  pif_store #(
    .DEPTH (MAX_FIGURES),
    .WIDTH (ROW_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fig_count_q[ADDR_W-1:0]),
    .wr_data_i ({in_i.kind, in_i.coord_f, in_i.coord_e, in_i.coord_d,
                 in_i.coord_c, in_i.coord_b, in_i.coord_a}),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[ADDR_W-1:0]),
    .rd_data_o (row_data)
  );

  // Unpack the figure row
  assign row_kind = row_data[ROW_W-1 -: KIND_W];

  always_comb begin
    for (int i = 0; i < NUM_COORDS; i++) begin
      coord[i] = row_data[i*COORD_BITS +: COORD_BITS];
    end
    for (int k = 0; k < 3; k++) begin
      vx[k] = OP_W'(coord[2*k]);
      vy[k] = OP_W'(coord[2*k+1]);
    end
  end

  assign pxe = OP_W'(px_q);
  assign pye = OP_W'(py_q);

  // Strict rectangle test
  assign rect_hit = (px_q > coord[0]) && (px_q < coord[2]) &&
                    (py_q < coord[1]) && (py_q > coord[3]);

  // Triangle edge endpoints for the current step
  always_comb begin
    case (step_q[2:1])
      2'd0: begin
        ax = vx[0]; ay = vy[0]; bx = vx[1]; by = vy[1];
      end
      2'd1: begin
        ax = vx[1]; ay = vy[1]; bx = vx[2]; by = vy[2];
      end
      default: begin
        ax = vx[2]; ay = vy[2]; bx = vx[0]; by = vy[0];
      end
    endcase
  end

  // Operand and accumulate selection
  always_comb begin
    if (row_kind == KIND_CIRC) begin
      case (step_q)
        3'd0: begin
          op_a = pxe - vx[0]; op_b = pxe - vx[0]; sel_op = MAC_LOAD;
        end
        3'd1: begin
          op_a = pye - vy[0]; op_b = pye - vy[0]; sel_op = MAC_ADD;
        end
        default: begin
          op_a = vx[1]; op_b = vx[1]; sel_op = MAC_RSUB;
        end
      endcase
      last_step = (step_q == STEP_CIRC_LAST);
    end else begin
      if (!step_q[0]) begin
        op_a = bx - ax; op_b = pye - ay; sel_op = MAC_LOAD;
      end else begin
        op_a = by - ay; op_b = pxe - ax; sel_op = MAC_SUB;
      end
      last_step = (step_q == STEP_TRI_LAST);
    end
  end

  pif_mac #(
    .OP_W (OP_W)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .sign_o (mac_sign)
  );

  // Handshake helpers
  assign in_ready  = (state_q == ST_IDLE);
  assign in_fire   = in_i.valid && in_ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign scan_done = ((idx_q + CNT_W'(1)) == fig_count_q);
  assign cur_fig   = FNUM_W'(idx_q + CNT_W'(1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    fig_count_d = fig_count_q;
    pnt_cnt_d   = pnt_cnt_q;
    idx_d       = idx_q;
    step_d      = step_q;
    hit_d       = hit_q;
    tri_pos_d   = tri_pos_q;
    tri_neg_d   = tri_neg_q;
    px_d        = px_q;
    py_d        = py_q;
    pend_v_d    = pend_v_q;
    pend_fig_d  = pend_fig_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_pnum_d  = out_pnum_q;
    out_fig_d   = out_fig_q;
    out_cont_d  = out_cont_q;
    out_last_d  = out_last_q;
    rd_en       = 1'b0;
    mac_ctrl    = '{mul_en: 1'b0, acc_en: 1'b0, op: MAC_LOAD};

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.cmd)
            CMD_CLEAR: begin
              fig_count_d = '0;
              pnt_cnt_d   = '0;
            end
            CMD_ADD: begin
              if (fig_count_q < FIG_MAX) begin
                fig_count_d = fig_count_q + CNT_W'(1);
              end
            end
            CMD_QUERY: begin
              if (pnt_cnt_q != PNUM_MAX) begin
                pnt_cnt_d = pnt_cnt_q + PNUM_W'(1);
              end
              px_d     = in_i.point_x;
              py_d     = in_i.point_y;
              idx_d    = '0;
              pend_v_d = 1'b0;
              state_d  = (fig_count_q == '0) ? ST_FINISH : ST_FETCH;
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        rd_en   = 1'b1;
        state_d = ST_DECODE;
      end

      ST_DECODE: begin
        case (row_kind)
          KIND_RECT: begin
            hit_d   = rect_hit;
            state_d = ST_RESULT;
          end
          KIND_CIRC, KIND_TRI: begin
            step_d  = '0;
            state_d = ST_MUL;
          end
          default: begin
            hit_d   = 1'b0;
            state_d = ST_RESULT;
          end
        endcase
      end

      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        // accumulator still holds the previous triangle edge
        if ((row_kind == KIND_TRI) && !step_q[0] && (step_q != '0)) begin
          tri_pos_d[step_q[2]] = mac_sign.pos;
          tri_neg_d[step_q[2]] = mac_sign.neg;
        end
        state_d = ST_ACC;
      end

      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        mac_ctrl.op     = sel_op;
        if (last_step) begin
          state_d = ST_SIGN;
        end else begin
          step_d  = step_q + 3'd1;
          state_d = ST_MUL;
        end
      end

      ST_SIGN: begin
        if (row_kind == KIND_CIRC) begin
          hit_d = mac_sign.pos && (coord[2] > 0);
        end else begin
          hit_d = ((&tri_pos_q) && mac_sign.pos) || ((&tri_neg_q) && mac_sign.neg);
        end
        state_d = ST_RESULT;
      end

      ST_RESULT: begin
        if (!hit_q || !pend_v_q || out_free) begin
          if (hit_q) begin
            if (pend_v_q) begin
              // an earlier hit now known not to be the last word
              out_valid_d = 1'b1;
              out_pnum_d  = pnt_cnt_q;
              out_fig_d   = pend_fig_q;
              out_cont_d  = 1'b1;
              out_last_d  = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_fig_d = cur_fig;
          end
          if (scan_done) begin
            state_d = ST_FINISH;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = ST_FETCH;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pnum_d  = pnt_cnt_q;
          out_fig_d   = pend_v_q ? pend_fig_q : '0;
          out_cont_d  = pend_v_q;
          out_last_d  = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fig_count_q <= '0;
      pnt_cnt_q   <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      hit_q       <= 1'b0;
      tri_pos_q   <= '0;
      tri_neg_q   <= '0;
      px_q        <= '0;
      py_q        <= '0;
      pend_v_q    <= 1'b0;
      pend_fig_q  <= '0;
      out_valid_q <= 1'b0;
      out_pnum_q  <= '0;
      out_fig_q   <= '0;
      out_cont_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fig_count_q <= fig_count_d;
      pnt_cnt_q   <= pnt_cnt_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
      tri_pos_q   <= tri_pos_d;
      tri_neg_q   <= tri_neg_d;
      px_q        <= px_d;
      py_q        <= py_d;
      pend_v_q    <= pend_v_d;
      pend_fig_q  <= pend_fig_d;
      out_valid_q <= out_valid_d;
      out_pnum_q  <= out_pnum_d;
      out_fig_q   <= out_fig_d;
      out_cont_q  <= out_cont_d;
      out_last_q  <= out_last_d;
    end
  end

  // Ports
  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.point_number  = out_pnum_q;
  assign out_o.figure_number = out_fig_q;
  assign out_o.contained     = out_cont_q;
  assign out_o.last          = out_last_q;

  // Assertions
  `PIF_ASSERT(a_mid_word_contained, clk_i, rst_ni, out_valid_q && !out_last_q |-> out_cont_q, "non-final word without a containing figure")
  `PIF_ASSERT(a_none_word_form, clk_i, rst_ni, out_valid_q && !out_cont_q |-> (out_fig_q == '0) && out_last_q, "malformed not-contained word")
  `PIF_ASSERT(a_pnum_nonzero, clk_i, rst_ni, out_valid_q |-> (out_pnum_q != '0), "result word with zero point number")
  `PIF_ASSERT(a_no_pending_idle, clk_i, rst_ni, (state_q == ST_IDLE) |-> !pend_v_q, "pending hit left over after a query")
  `PIF_ASSERT_NR(a_count_bound, clk_i, fig_count_q <= FIG_MAX, "figure count past table size")

endmodule

FILE: sim/tb_point_in_figure_table_test.sv
module tb_point_in_figure_table_test;
  import pif_pkg::*;

  localparam int CW          = 24;
  localparam int MAX_FIG     = 16;
  localparam int LIMIT       = 4000000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 300;
  localparam int RAND_WORDS  = 400;

  // unused codes: the block ignores the command, and an unknown kind never contains a point
  localparam logic [CMD_W-1:0]  CMD_NONE  = 2'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KIND_W-1:0] kind;
    logic [CW-1:0]     ca, cb, cc, cd, ce, cf;
    logic [CW-1:0]     px, py;
  } fig_word_t;

  typedef struct packed {
    logic [PNUM_W-1:0] pnum;
    logic [FNUM_W-1:0] fnum;
    logic              hit;
    logic              fin;
  } hit_t;

  typedef struct {
    fig_word_t w;
    bit        typed;
    hit_t      want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pif_in_if #(.COORD_BITS(CW)) in_bus ();
  pif_out_if                   out_bus ();

  point_in_figure_table_test #(
    .MAX_FIGURES(MAX_FIG),
    .COORD_BITS (CW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted table state
  int unsigned       fig_cnt;
  logic [PNUM_W-1:0] pt_cnt;
  logic [KIND_W-1:0] fig_kind_tab [MAX_FIG];
  longint            fig_crd_tab  [MAX_FIG][NUM_COORDS];

  hit_t owed_words[$];
  row_t dir_rows[$];

  int  n_words, n_query, n_add, n_clear, n_checked, n_hits, n_err;
  int  cycle_cnt;
  int  stall_left, hold_left;
  bit  hold_go   = 1'b0;
  bit  fast_mode = 1'b0;

  function automatic longint sx(input logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  // sign of cross((b - a), (p - a))
  function automatic int side_of(input longint ax, ay, bx, by, px, py);
    longint l;
    l = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    return (l > 0) ? 1 : ((l < 0) ? -1 : 0);
  endfunction

  // strict containment test of one stored figure
  function automatic bit covers(input int idx, input longint x, input longint y);
    longint a, b, c, d, e, f;
    int     s1, s2, s3;
    a = fig_crd_tab[idx][0];
    b = fig_crd_tab[idx][1];
    c = fig_crd_tab[idx][2];
    d = fig_crd_tab[idx][3];
    e = fig_crd_tab[idx][4];
    f = fig_crd_tab[idx][5];
    case (fig_kind_tab[idx])
      KIND_RECT: return x > a && x < c && y < b && y > d;
      KIND_CIRC: begin
        if (c <= 0) return 1'b0;
        return (x - a) * (x - a) + (y - b) * (y - b) < c * c;
      end
      KIND_TRI: begin
        s1 = side_of(a, b, c, d, x, y);
        s2 = side_of(c, d, e, f, x, y);
        s3 = side_of(e, f, a, b, x, y);
        return (s1 > 0 && s2 > 0 && s3 > 0) || (s1 < 0 && s2 < 0 && s3 < 0);
      end
      default: return 1'b0;
    endcase
  endfunction

  // table response to one accepted word
  function automatic void figure_table_step(input fig_word_t w, ref hit_t res[$]);
    longint x, y;
    hit_t   h;
    res.delete();
    case (w.cmd)
      CMD_CLEAR: begin
        fig_cnt = 0;
        pt_cnt  = '0;
      end
      CMD_ADD: begin
        if (fig_cnt < MAX_FIG) begin
          fig_kind_tab[fig_cnt]   = w.kind;
          fig_crd_tab[fig_cnt][0] = sx(w.ca);
          fig_crd_tab[fig_cnt][1] = sx(w.cb);
          fig_crd_tab[fig_cnt][2] = sx(w.cc);
          fig_crd_tab[fig_cnt][3] = sx(w.cd);
          fig_crd_tab[fig_cnt][4] = sx(w.ce);
          fig_crd_tab[fig_cnt][5] = sx(w.cf);
          fig_cnt++;
        end
      end
      CMD_QUERY: begin
        if (pt_cnt != PNUM_MAX) pt_cnt++;
        x = sx(w.px);
        y = sx(w.py);
        for (int i = 0; i < fig_cnt; i++) begin
          if (covers(i, x, y)) begin
            h   = '{pt_cnt, FNUM_W'(i + 1), 1'b1, 1'b0};
            res = {res, h};
          end
        end
        if (res.size() == 0) begin
          h   = '{pt_cnt, FNUM_W'(0), 1'b0, 1'b1};
          res = {res, h};
        end else begin
          res[res.size() - 1].fin = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic fig_word_t mk(input logic [CMD_W-1:0] c, input logic [KIND_W-1:0] k,
                                   input int v0, v1, v2, v3, v4, v5, x, y);
    fig_word_t w;
    w.cmd  = c;
    w.kind = k;
    w.ca   = v0[CW-1:0];
    w.cb   = v1[CW-1:0];
    w.cc   = v2[CW-1:0];
    w.cd   = v3[CW-1:0];
    w.ce   = v4[CW-1:0];
    w.cf   = v5[CW-1:0];
    w.px   = x[CW-1:0];
    w.py   = y[CW-1:0];
    return w;
  endfunction

  function automatic fig_word_t add_fig(input logic [KIND_W-1:0] k,
                                        input int v0, v1, v2, v3,
                                        input int v4 = 0, input int v5 = 0);
    return mk(CMD_ADD, k, v0, v1, v2, v3, v4, v5, 0, 0);
  endfunction

  function automatic fig_word_t ask(input int x, input int y);
    return mk(CMD_QUERY, KIND_RECT, 0, 0, 0, 0, 0, 0, x, y);
  endfunction

  function automatic fig_word_t wipe();
    return mk(CMD_CLEAR, KIND_RECT, 0, 0, 0, 0, 0, 0, 0, 0);
  endfunction

  function automatic void row(input fig_word_t w, input bit typed = 1'b0,
                              input hit_t want = '0);
    row_t r;
    r.w      = w;
    r.typed  = typed;
    r.want   = want;
    dir_rows = {dir_rows, r};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick(input int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  // offer one word, wait for it to be taken, then maybe go idle
  task automatic send_word(input fig_word_t w, input bit typed = 1'b0,
                           input hit_t want = '0);
    hit_t res[$];
    int   g;
    in_bus.valid   <= 1'b1;
    in_bus.cmd     <= w.cmd;
    in_bus.kind    <= w.kind;
    in_bus.coord_a <= w.ca;
    in_bus.coord_b <= w.cb;
    in_bus.coord_c <= w.cc;
    in_bus.coord_d <= w.cd;
    in_bus.coord_e <= w.ce;
    in_bus.coord_f <= w.cf;
    in_bus.point_x <= w.px;
    in_bus.point_y <= w.py;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    figure_table_step(w, res);
    if (typed) owed_words = {owed_words, want};
    else owed_words = {owed_words, res};
    n_words++;
    if (w.cmd == CMD_QUERY) n_query++;
    if (w.cmd == CMD_ADD) n_add++;
    if (w.cmd == CMD_CLEAR) n_clear++;
    g = fast_mode ? 0 : idle_len();
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
  endtask

  // random part: mostly clear / add / query sequences, some noise words
  task automatic run_random();
    longint    cxq[$], cyq[$], bxq[$], byq[$];
    int        base, s, nf, nq, r, cx, cy, w, h, j, m, x, y;
    int        v[6];
    logic [KIND_W-1:0] kd;
    bit        paused;
    base   = n_words;
    paused = 1'b0;
    hold_go <= 1'b1;
    while (n_words - base < RAND_WORDS) begin
      if (!paused && n_words - base >= RAND_WORDS / 2) begin
        paused = 1'b1;
        drain();
      end
      fast_mode <= ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_word(mk(CMD_W'($urandom_range(0, 3)), KIND_W'($urandom_range(0, 3)),
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom));
      end else begin
        if ($urandom_range(0, 3) != 0) send_word(wipe());
        r = $urandom_range(0, 99);
        if (r < 80) nf = $urandom_range(1, 6);
        else if (r < 95) nf = $urandom_range(7, 16);
        else nf = $urandom_range(17, 20);
        r = $urandom_range(0, 9);
        s = (r < 5) ? 2048 : ((r < 8) ? (1 << 18) : 0);
        cxq.delete(); cyq.delete(); bxq.delete(); byq.delete();
        for (int k = 0; k < nf; k++) begin
          r  = $urandom_range(0, 19);
          kd = (r == 0) ? KIND_NONE : ((r < 7) ? KIND_RECT : ((r < 13) ? KIND_CIRC : KIND_TRI));
          foreach (v[i]) v[i] = $urandom;
          if (s == 0) begin
            // full-range figure with arbitrary values
            cx  = int'(sx(v[0][CW-1:0]));
            cy  = int'(sx(v[1][CW-1:0]));
            bxq = {bxq, longint'(cx)};
            byq = {byq, longint'(cy)};
          end else begin
            cx = pick(s);
            cy = pick(s);
            w  = $urandom_range(1, s);
            h  = $urandom_range(1, s);
            case (kd)
              KIND_RECT: begin
                v[0] = cx - w; v[1] = cy + h; v[2] = cx + w; v[3] = cy - h;
                if ($urandom_range(0, 9) == 0) begin
                  v[0] = cx + w; v[2] = cx - w;
                end
                bxq = {bxq, longint'(cx - w)};
                byq = {byq, longint'(cy)};
              end
              KIND_CIRC: begin
                v[0] = cx; v[1] = cy; v[2] = w;
                r = $urandom_range(0, 19);
                if (r == 0) v[2] = -w;
                if (r == 1) v[2] = 0;
                bxq = {bxq, longint'(cx + w)};
                byq = {byq, longint'(cy)};
              end
              KIND_TRI: begin
                v[0] = cx - w;       v[1] = cy - h;
                v[2] = cx + w;       v[3] = cy + pick(h);
                v[4] = cx + pick(w); v[5] = cy + h;
                if ($urandom_range(0, 1) == 0) begin
                  j = v[2]; v[2] = v[4]; v[4] = j;
                  j = v[3]; v[3] = v[5]; v[5] = j;
                end
                // collinear vertices now and then
                if ($urandom_range(0, 9) == 0) begin
                  v[4] = 2 * v[2] - v[0];
                  v[5] = 2 * v[3] - v[1];
                end
                bxq = {bxq, longint'(v[0])};
                byq = {byq, longint'(v[1])};
              end
              default: begin
                bxq = {bxq, longint'(cx)};
                byq = {byq, longint'(cy)};
              end
            endcase
          end
          cxq = {cxq, longint'(cx)};
          cyq = {cyq, longint'(cy)};
          send_word(mk(CMD_ADD, kd, v[0], v[1], v[2], v[3], v[4], v[5],
                       $urandom, $urandom));
        end
        nq = $urandom_range(1, 6);
        for (int k = 0; k < nq; k++) begin
          m = $urandom_range(0, 99);
          j = $urandom_range(0, cxq.size() - 1);
          if (m < 45) begin
            x = int'(cxq[j]) + pick((s == 0) ? 256 : s / 8 + 1);
            y = int'(cyq[j]) + pick((s == 0) ? 256 : s / 8 + 1);
          end else if (m < 65) begin
            x = int'(bxq[j]);
            y = int'(byq[j]);
          end else if (s == 0) begin
            x = $urandom;
            y = $urandom;
          end else begin
            x = pick(2 * s);
            y = pick(2 * s);
          end
          send_word(mk(CMD_QUERY, KIND_W'($urandom_range(0, 3)), $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, x, y));
        end
      end
    end
    fast_mode <= 1'b0;
  endtask

  // result receiver: random stalls, one long hold on request
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_go       <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else if (fast_mode) begin
      out_bus.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left    <= idle_len();
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // compare each taken result word with the oldest one owed
  always @(posedge clk_i) begin : result_check
    hit_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.pnum = out_bus.point_number;
      got.fnum = out_bus.figure_number;
      got.hit  = out_bus.contained;
      got.fin  = out_bus.last;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected result pnum=%0d fig=%0d contained=%0b last=%0b",
                 $time, got.pnum, got.fnum, got.hit, got.fin);
        n_err++;
      end else begin
        want = owed_words.pop_front();
        n_checked++;
        if (got.hit === 1'b1) n_hits++;
        if (got.pnum !== want.pnum || got.fnum !== want.fnum ||
            got.hit !== want.hit || got.fin !== want.fin) begin
          $display("%0t: mismatch expected pnum=%0d fig=%0d contained=%0b last=%0b",
                   $time, want.pnum, want.fnum, want.hit, want.fin);
          $display("%0t:          actual   pnum=%0d fig=%0d contained=%0b last=%0b",
                   $time, got.pnum, got.fnum, got.hit, got.fin);
          n_err++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("%0t: timeout with %0d result words still owed", $time, owed_words.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.cmd     = CMD_CLEAR;
    in_bus.kind    = KIND_RECT;
    in_bus.coord_a = '0;
    in_bus.coord_b = '0;
    in_bus.coord_c = '0;
    in_bus.coord_d = '0;
    in_bus.coord_e = '0;
    in_bus.coord_f = '0;
    in_bus.point_x = '0;
    in_bus.point_y = '0;
    out_bus.ready  = 1'b0;
    rst_ni         = 1'b0;
    fig_cnt        = 0;
    pt_cnt         = '0;

    // directed table; 256 is 1.0
    row(ask(0, 0), 1'b1, hit_t'{16'd1, 5'd0, 1'b0, 1'b1});
    row(mk(CMD_NONE, KIND_NONE, -1, -1, -1, -1, -1, -1, -1, -1));
    row(ask(0, 0), 1'b1, hit_t'{16'd2, 5'd0, 1'b0, 1'b1});
    row(add_fig(KIND_RECT, -2560, 2560, 2560, -2560));
    row(ask(0, 0), 1'b1, hit_t'{16'd3, 5'd1, 1'b1, 1'b1});
    row(ask(2560, 0), 1'b1, hit_t'{16'd4, 5'd0, 1'b0, 1'b1});
    row(add_fig(KIND_CIRC, 0, 0, 1280, 0));
    row(ask(0, 0));
    row(ask(1280, 0));
    row(add_fig(KIND_CIRC, 0, 0, 0, 0));
    row(add_fig(KIND_CIRC, 0, 0, -1280, 0));
    row(add_fig(KIND_TRI, 0, 0, 2560, 0, 0, 2560));
    row(add_fig(KIND_TRI, 0, 0, 0, 2560, 2560, 0));
    row(add_fig(KIND_NONE, -2560, 2560, 2560, -2560, 0, 0));
    row(ask(256, 256));
    row(ask(256, 0));
    row(add_fig(KIND_RECT, -8388608, 8388607, 8388607, -8388608));
    row(add_fig(KIND_CIRC, -8388608, -8388608, 8388607, 0));
    row(add_fig(KIND_TRI, -8388608, -8388608, 8388607, -8388608, -8388608, 8388607));
    row(ask(8388607, -8388608));
    row(ask(-8388607, -8388607));
    row(wipe());
    row(ask(0, 0), 1'b1, hit_t'{16'd1, 5'd0, 1'b0, 1'b1});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);
    drain();

    run_random();
    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d words: %0d queries, %0d adds, %0d clears", n_words, n_query,
             n_add, n_clear);
    $display("checked %0d result words, %0d of them hits, %0d mismatches", n_checked,
             n_hits, n_err);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: point_in_figure_table_test.f
+incdir+design
design/pif_pkg.sv
design/pif_in_if.sv
design/pif_out_if.sv
design/pif_store.sv
design/pif_mac.sv
design/point_in_figure_table_test.sv
sim/tb_point_in_figure_table_test.sv
